// File: hdl/m4inv_pkg.sv
// Shared types, constants and index helpers for the 4x4 fixed-point matrix inverter.
// No dependencies; imported by every module of the block.
package m4inv_pkg;

  localparam int ELEM_W      = 32;
  localparam int FRAC_BITS   = 16;
  localparam int IDX_W       = 4;
  localparam int PROD_W      = 2 * ELEM_W;
  localparam int CMAG_W      = 3 * ELEM_W;        // cofactor magnitude
  localparam int COF_W       = CMAG_W + 1;        // signed cofactor
  localparam int ACC_W       = 4 * ELEM_W + 4;    // signed determinant accumulator
  localparam int DMAG_W      = ACC_W - 1;
  localparam int DIV_STEPS   = 2 * FRAC_BITS;
  localparam int CNT_W       = $clog2(DIV_STEPS);
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  localparam logic [IDX_W-1:0]  LAST_IDX  = {IDX_W{1'b1}};
  localparam logic [2:0]        LAST_TERM = 3'd5;
  localparam logic [ELEM_W-1:0] POS_MAX   = {1'b0, {(ELEM_W-1){1'b1}}};
  localparam logic [ELEM_W-1:0] NEG_MIN   = {1'b1, {(ELEM_W-1){1'b0}}};

  typedef struct packed {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  idx;
    logic              last;
  } elem_item_t;

  function automatic logic [ELEM_W-1:0] mag(input logic [ELEM_W-1:0] v);
    return v[ELEM_W-1] ? (~v + 1'b1) : v;
  endfunction

  // terms 1, 2 and 5 of a 3x3 minor enter with a minus sign
  function automatic logic term_minus(input logic [2:0] term);
    return (term == 3'd1) || (term == 3'd2) || (term == 3'd5);
  endfunction

  // element index for position pos of term "term" in the minor of cofactor cidx
  function automatic logic [IDX_W-1:0] term_elem(input logic [IDX_W-1:0] cidx,
                                                 input logic [2:0] term,
                                                 input logic [1:0] pos);
    logic [5:0] cols;
    logic [1:0] b;
    logic [1:0] rr;
    logic [1:0] cc;
    case (term)
      3'd0:    cols = {2'd2, 2'd1, 2'd0};
      3'd1:    cols = {2'd1, 2'd2, 2'd0};
      3'd2:    cols = {2'd2, 2'd0, 2'd1};
      3'd3:    cols = {2'd0, 2'd2, 2'd1};
      3'd4:    cols = {2'd1, 2'd0, 2'd2};
      3'd5:    cols = {2'd0, 2'd1, 2'd2};
      default: cols = {2'd2, 2'd1, 2'd0};
    endcase
    case (pos)
      2'd0:    b = cols[1:0];
      2'd1:    b = cols[3:2];
      default: b = cols[5:4];
    endcase
    rr = (pos < cidx[3:2]) ? pos : pos + 2'd1;
    cc = (b < cidx[1:0]) ? b : b + 2'd1;
    return {rr, cc};
  endfunction

endpackage

// File: hdl/m4inv_front.sv
// Front end: accepts matrix elements, tags each with its position and the end of a matrix.
// Depends on m4inv_pkg.
module m4inv_front
  import m4inv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              element_valid,
  input  logic [ELEM_W-1:0] element_value,
  output logic              element_stall,
  input  logic              queue_full,
  output logic              push,
  output elem_item_t        item
);

  logic [IDX_W-1:0] load_count;

  assign element_stall = queue_full;
  assign push          = element_valid && !queue_full;

  always_comb begin
    item.value = element_value;
    item.idx   = load_count;
    item.last  = (load_count == LAST_IDX);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      load_count <= '0;
    end else if (push) begin
      load_count <= load_count + 1'b1;
    end
  end

endmodule

// File: hdl/m4inv_fifo.sv
// Short queue of tagged elements between the front end and the compute engine.
// Depends on m4inv_pkg.
module m4inv_fifo
  import m4inv_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       push,
  input  elem_item_t push_item,
  input  logic       pop,
  output elem_item_t pop_item,
  output logic       full,
  output logic       empty
);

  elem_item_t        slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   count;

  assign full     = (count == (QPTR_W+1)'(QUEUE_DEPTH));
  assign empty    = (count == '0);
  assign pop_item = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: hdl/m4inv_back.sv
// Compute engine: cofactors and determinant on one shared 32x32 multiplier,
// then a restoring divider per result, with an output register. Depends on m4inv_pkg.
module m4inv_back
  import m4inv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  elem_item_t        q_item,
  input  logic              q_empty,
  output logic              q_pop,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [ELEM_W-1:0] result_value,
  output logic [IDX_W-1:0]  result_index,
  output logic              singular,
  output logic              saturated,
  output logic              last_result
);

  localparam logic [4:0] S_LOAD = 5'd0;
  localparam logic [4:0] S_T0   = 5'd1;
  localparam logic [4:0] S_T1   = 5'd2;
  localparam logic [4:0] S_T2   = 5'd3;
  localparam logic [4:0] S_T3   = 5'd4;
  localparam logic [4:0] S_CW0  = 5'd5;
  localparam logic [4:0] S_CW1  = 5'd6;
  localparam logic [4:0] S_D0   = 5'd7;
  localparam logic [4:0] S_D1   = 5'd8;
  localparam logic [4:0] S_D2   = 5'd9;
  localparam logic [4:0] S_D3   = 5'd10;
  localparam logic [4:0] S_DW0  = 5'd11;
  localparam logic [4:0] S_DW1  = 5'd12;
  localparam logic [4:0] S_V0   = 5'd13;
  localparam logic [4:0] S_V1   = 5'd14;
  localparam logic [4:0] S_VDIV = 5'd15;
  localparam logic [4:0] S_VFIN = 5'd16;
  localparam logic [4:0] S_OUT  = 5'd17;

  logic [4:0]        state;
  logic [ELEM_W-1:0] mat [16];
  logic [COF_W-1:0]  cof [16];
  logic [IDX_W-1:0]  cidx;
  logic [2:0]        term;
  logic              tneg;
  logic [ELEM_W-1:0] ra;
  logic [ELEM_W-1:0] ph;
  logic [ELEM_W-1:0] m2;
  logic [ELEM_W-1:0] am;
  logic [CMAG_W-1:0] cm;
  logic              dneg;

  logic [PROD_W-1:0] prod;
  logic              acc_en_q;
  logic [1:0]        acc_sh_q;
  logic              acc_neg_q;
  logic [ACC_W-1:0]  acc;

  logic              detz;
  logic              dsign;
  logic [DMAG_W-1:0] dmag;
  logic [CMAG_W-1:0] num;
  logic              nneg;
  logic [DMAG_W-1:0] rem;
  logic [DIV_STEPS-1:0] quo;
  logic [CNT_W-1:0]  cnt;
  logic [ELEM_W-1:0] res_val;
  logic              res_sing;
  logic              res_sat;

  // combinational controls
  logic [IDX_W-1:0]  rd_addr;
  logic [IDX_W-1:0]  cof_addr;
  logic [ELEM_W-1:0] elem;
  logic [ELEM_W-1:0] emag;
  logic              esgn;
  logic [COF_W-1:0]  cof_rd;
  logic [COF_W-1:0]  cof_neg;
  logic [ELEM_W-1:0] mul_a;
  logic [ELEM_W-1:0] mul_b;
  logic              acc_en;
  logic [1:0]        acc_sh;
  logic              acc_neg;
  logic              acc_clr;
  logic [ACC_W-1:0]  addend;
  logic [ACC_W-1:0]  acc_next;
  logic [ACC_W-1:0]  acc_abs;
  logic [DMAG_W:0]   rem2;
  logic [DMAG_W:0]   diff;
  logic              ge;
  logic              rneg;
  logic              out_load;

  assign elem    = mat[rd_addr];
  assign emag    = mag(elem);
  assign esgn    = elem[ELEM_W-1];
  assign cof_rd  = cof[cof_addr];
  assign cof_neg = cof_rd[COF_W-1] ? (~cof_rd + 1'b1) : cof_rd;
  assign acc_abs = acc[ACC_W-1] ? (~acc + 1'b1) : acc;
  assign rem2    = {rem, 1'b0};
  assign diff    = rem2 - {1'b0, dmag};
  assign ge      = (rem2 >= {1'b0, dmag});
  assign rneg    = nneg ^ dsign;
  assign out_load = !result_valid || !result_stall;

  always_comb begin
    rd_addr  = '0;
    cof_addr = cidx;
    mul_a    = '0;
    mul_b    = '0;
    acc_en   = 1'b0;
    acc_sh   = 2'd0;
    acc_neg  = 1'b0;
    acc_clr  = 1'b0;
    q_pop    = 1'b0;
    case (state)
      S_LOAD: begin
        q_pop   = !q_empty;
        acc_clr = 1'b1;
      end
      S_T0: rd_addr = term_elem(cidx, term, 2'd0);
      S_T1: begin
        rd_addr = term_elem(cidx, term, 2'd1);
        mul_a   = ra;
        mul_b   = emag;
      end
      S_T2: begin
        rd_addr = term_elem(cidx, term, 2'd2);
        mul_a   = prod[ELEM_W-1:0];
        mul_b   = emag;
        acc_en  = 1'b1;
        acc_neg = tneg ^ esgn;
      end
      S_T3: begin
        mul_a   = ph;
        mul_b   = m2;
        acc_en  = 1'b1;
        acc_sh  = 2'd1;
        acc_neg = tneg;
      end
      S_CW1: acc_clr = 1'b1;
      S_D0:  rd_addr = {2'b00, cidx[1:0]};
      S_D1: begin
        mul_a   = cm[ELEM_W-1:0];
        mul_b   = am;
        acc_en  = 1'b1;
        acc_neg = dneg;
      end
      S_D2: begin
        mul_a   = cm[2*ELEM_W-1:ELEM_W];
        mul_b   = am;
        acc_en  = 1'b1;
        acc_sh  = 2'd1;
        acc_neg = dneg;
      end
      S_D3: begin
        mul_a   = cm[3*ELEM_W-1:2*ELEM_W];
        mul_b   = am;
        acc_en  = 1'b1;
        acc_sh  = 2'd2;
        acc_neg = dneg;
      end
      S_V0: cof_addr = {cidx[1:0], cidx[3:2]};   // transpose: adjugate
      default: begin
      end
    endcase
  end

  always_comb begin
    case (acc_sh_q)
      2'd1:    addend = {{(ACC_W-PROD_W-ELEM_W){1'b0}}, prod, {ELEM_W{1'b0}}};
      2'd2:    addend = {{(ACC_W-PROD_W-2*ELEM_W){1'b0}}, prod, {(2*ELEM_W){1'b0}}};
      default: addend = {{(ACC_W-PROD_W){1'b0}}, prod};
    endcase
    acc_next = acc_neg_q ? (acc - addend) : (acc + addend);
  end

  // shared multiplier, product registered with its accumulate tag
  always_ff @(posedge clk) begin
    prod      <= mul_a * mul_b;
    acc_sh_q  <= acc_sh;
    acc_neg_q <= acc_neg;
    if (acc_clr) begin
      acc <= '0;
    end else if (acc_en_q) begin
      acc <= acc_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc_en_q <= 1'b0;
    end else begin
      acc_en_q <= acc_en;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mat[q_item.idx] <= q_item.value;
    end
    if (state == S_CW1) begin
      cof[cidx] <= acc[COF_W-1:0];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state)
      S_T0: begin
        ra   <= emag;
        tneg <= esgn ^ term_minus(term) ^ cidx[2] ^ cidx[0];
      end
      S_T1: tneg <= tneg ^ esgn;
      S_T2: begin
        ph   <= prod[PROD_W-1:ELEM_W];
        m2   <= emag;
        tneg <= tneg ^ esgn;
      end
      S_D0: begin
        am   <= emag;
        cm   <= cof_neg[CMAG_W-1:0];
        dneg <= esgn ^ cof_rd[COF_W-1];
      end
      S_DW1: begin
        detz  <= (acc == '0);
        dsign <= acc[ACC_W-1];
        dmag  <= acc_abs[DMAG_W-1:0];
      end
      S_V0: begin
        num  <= cof_neg[CMAG_W-1:0];
        nneg <= cof_rd[COF_W-1];
      end
      S_V1: begin
        rem      <= DMAG_W'(num);
        quo      <= '0;
        res_sing <= detz;
        res_sat  <= !detz && (DMAG_W'(num) >= dmag);
        if (detz) begin
          res_val <= '0;
        end else begin
          res_val <= rneg ? NEG_MIN : POS_MAX;
        end
      end
      S_VDIV: begin
        rem <= ge ? diff[DMAG_W-1:0] : rem2[DMAG_W-1:0];
        quo <= {quo[DIV_STEPS-2:0], ge};
      end
      S_VFIN: begin
        if (rneg) begin
          res_sat <= (ELEM_W'(quo) > NEG_MIN);
          res_val <= (ELEM_W'(quo) > NEG_MIN) ? NEG_MIN : (~ELEM_W'(quo) + 1'b1);
        end else begin
          res_sat <= (ELEM_W'(quo) > POS_MAX);
          res_val <= (ELEM_W'(quo) > POS_MAX) ? POS_MAX : ELEM_W'(quo);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      cidx  <= '0;
      term  <= '0;
      cnt   <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          cidx <= '0;
          term <= '0;
          if (q_pop && q_item.last) begin
            state <= S_T0;
          end
        end
        S_T0: state <= S_T1;
        S_T1: state <= S_T2;
        S_T2: state <= S_T3;
        S_T3: begin
          if (term == LAST_TERM) begin
            state <= S_CW0;
          end else begin
            term  <= term + 1'b1;
            state <= S_T0;
          end
        end
        S_CW0: state <= S_CW1;
        S_CW1: begin
          term <= '0;
          cidx <= cidx + 1'b1;
          if (cidx == LAST_IDX) begin
            state <= S_D0;
          end else begin
            state <= S_T0;
          end
        end
        S_D0: state <= S_D1;
        S_D1: state <= S_D2;
        S_D2: state <= S_D3;
        S_D3: begin
          if (cidx[1:0] == 2'd3) begin
            state <= S_DW0;
          end else begin
            cidx  <= cidx + 1'b1;
            state <= S_D0;
          end
        end
        S_DW0: state <= S_DW1;
        S_DW1: begin
          cidx  <= '0;
          state <= S_V0;
        end
        S_V0: state <= S_V1;
        S_V1: begin
          cnt <= '0;
          if (detz || (DMAG_W'(num) >= dmag)) begin
            state <= S_OUT;
          end else begin
            state <= S_VDIV;
          end
        end
        S_VDIV: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(DIV_STEPS - 1)) begin
            state <= S_VFIN;
          end
        end
        S_VFIN: state <= S_OUT;
        S_OUT: begin
          if (out_load) begin
            cidx <= cidx + 1'b1;
            if (cidx == LAST_IDX) begin
              state <= S_LOAD;
            end else begin
              state <= S_V0;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (state == S_OUT && out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_load) begin
      result_value <= res_val;
      result_index <= cidx;
      singular     <= res_sing;
      saturated    <= res_sat;
      last_result  <= (cidx == LAST_IDX);
    end
  end

endmodule

// File: hdl/matrix4_inverse.sv
// After the 16th element, the block computes the 16 cofactors, then the determinant, then each
// result in turn with a 32-step restoring divider, which is skipped for a result when singular or
// when the quotient is known to overflow before dividing.
// The matrix rate is set by the shared multiplier and the one-bit-per-cycle divider; no new
// matrix is loaded while one is in work, and a 4-deep element queue absorbs input while busy.
// Reset (rst, synchronous): empties the queue, restarts element counting, drops any result.
// Top level; depends on m4inv_pkg, m4inv_front, m4inv_fifo, m4inv_back.
module matrix4_inverse
  import m4inv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              element_valid,
  output logic              element_stall,
  input  logic [ELEM_W-1:0] element_value,
  output logic              result_valid,
  input  logic              result_stall,
  output logic [ELEM_W-1:0] result_value,
  output logic [IDX_W-1:0]  result_index,
  output logic              singular,
  output logic              saturated,
  output logic              last_result
);

  elem_item_t push_item;
  elem_item_t pop_item;
  logic       push;
  logic       pop;
  logic       full;
  logic       empty;

  m4inv_front u_front (
    .clk           (clk),
    .rst           (rst),
    .element_valid (element_valid),
    .element_value (element_value),
    .element_stall (element_stall),
    .queue_full    (full),
    .push          (push),
    .item          (push_item)
  );

  m4inv_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .full      (full),
    .empty     (empty)
  );

  m4inv_back u_back (
    .clk          (clk),
    .rst          (rst),
    .q_item       (pop_item),
    .q_empty      (empty),
    .q_pop        (pop),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_value (result_value),
    .result_index (result_index),
    .singular     (singular),
    .saturated    (saturated),
    .last_result  (last_result)
  );

endmodule

// File: hdl/m4inv_chk.sv
// Port-level checks for matrix4_inverse, attached by bind.
// Depends on m4inv_pkg.
module m4inv_chk
  import m4inv_pkg::*;
(
  input logic              clk,
  input logic              rst,
  input logic              result_valid,
  input logic              result_stall,
  input logic [ELEM_W-1:0] result_value,
  input logic [IDX_W-1:0]  result_index,
  input logic              singular,
  input logic              saturated,
  input logic              last_result
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    result_valid && result_stall |=> result_valid && $stable(result_index)
      && $stable(result_value))
    else $error("stalled result changed");

  a_singular: assert property (@(posedge clk) disable iff (rst)
    result_valid && singular |-> result_value == '0 && !saturated)
    else $error("singular result not zero");

  a_clamp: assert property (@(posedge clk) disable iff (rst)
    result_valid && saturated |-> result_value == POS_MAX || result_value == NEG_MIN)
    else $error("saturated result not at a limit");

  a_last: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> last_result == (result_index == LAST_IDX))
    else $error("last flag on wrong item");

  a_reset: assert property (@(posedge clk) rst |=> !result_valid)
    else $error("result valid after reset");

endmodule

bind matrix4_inverse m4inv_chk u_chk (
  .clk          (clk),
  .rst          (rst),
  .result_valid (result_valid),
  .result_stall (result_stall),
  .result_value (result_value),
  .result_index (result_index),
  .singular     (singular),
  .saturated    (saturated),
  .last_result  (last_result)
);

// File: tb/matrix4_inverse_checker.sv
// Checker for the 4x4 fixed-point matrix inverter: watches both channels, rebuilds each
// matrix, predicts the 16 inverse elements and compares them in order.
// Depends on m4inv_pkg for widths and limits.
`timescale 1ns / 100ps
module matrix4_inverse_checker
  import m4inv_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              element_valid,
  input  logic              element_stall,
  input  logic [ELEM_W-1:0] element_value,
  input  logic              result_valid,
  input  logic              result_stall,
  input  logic [ELEM_W-1:0] result_value,
  input  logic [IDX_W-1:0]  result_index,
  input  logic              singular,
  input  logic              saturated,
  input  logic              last_result,
  output int                fail_count,
  output int                pending,
  output int                results_seen,
  output int                singular_seen,
  output int                sat_seen
);

  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic [ELEM_W-1:0] value;
    logic [IDX_W-1:0]  index;
    logic              sing;
    logic              sat;
    logic              last;
  } inv_elem_t;

  logic signed [ELEM_W-1:0] matrix_elems [16];
  logic [3:0]               loaded;
  inv_elem_t                inverse_q [$];

  assign pending = inverse_q.size();

  task automatic report(input string what, input longint got, input longint want);
    if (fail_count < 30)
      $display("mismatch %s: got %0h expected %0h", what, got, want);
    fail_count++;
  endtask

  // signed 3x3 minor with the checkerboard sign applied
  function automatic wide_t cofactor(input int row, input int col);
    int    r [3];
    int    c [3];
    int    n;
    wide_t a [3][3];
    wide_t d;
    n = 0;
    for (int k = 0; k < 4; k++) if (k != row) begin r[n] = k; n++; end
    n = 0;
    for (int k = 0; k < 4; k++) if (k != col) begin c[n] = k; n++; end
    for (int i = 0; i < 3; i++)
      for (int j = 0; j < 3; j++) a[i][j] = matrix_elems[4 * r[i] + c[j]];
    d = a[0][0] * (a[1][1] * a[2][2] - a[1][2] * a[2][1])
      - a[0][1] * (a[1][0] * a[2][2] - a[1][2] * a[2][0])
      + a[0][2] * (a[1][0] * a[2][1] - a[1][1] * a[2][0]);
    return ((row + col) % 2) ? -d : d;
  endfunction

  task automatic predict_inverse();
    wide_t     cof [16];
    wide_t     det;
    wide_t     quo;
    wide_t     hi;
    wide_t     lo;
    inv_elem_t e;
    det = 0;
    for (int k = 0; k < 16; k++) cof[k] = cofactor(k / 4, k % 4);
    for (int j = 0; j < 4; j++) det += wide_t'(matrix_elems[j]) * cof[j];
    hi = wide_t'(signed'(POS_MAX));
    lo = wide_t'(signed'(NEG_MIN));
    for (int k = 0; k < 16; k++) begin
      e.index = k[3:0];
      e.last  = (k == 15);
      e.sing  = (det == 0);
      e.sat   = 1'b0;
      if (det == 0) begin
        e.value = '0;
      end else begin
        quo = (cof[4 * (k % 4) + k / 4] <<< (2 * FRAC_BITS)) / det;
        if (quo > hi) begin
          quo = hi;
          e.sat = 1'b1;
        end else if (quo < lo) begin
          quo = lo;
          e.sat = 1'b1;
        end
        e.value = quo[ELEM_W-1:0];
      end
      inverse_q.push_back(e);
    end
  endtask

  always @(posedge clk) begin
    inv_elem_t w;
    if (rst) begin
      loaded <= '0;
      inverse_q.delete();
      fail_count <= 0;
      results_seen <= 0;
      singular_seen <= 0;
      sat_seen <= 0;
    end else begin
      if (result_valid && !result_stall) begin
        results_seen <= results_seen + 1;
        if (inverse_q.size() == 0) begin
          report("unexpected result index", result_index, 0);
        end else begin
          w = inverse_q.pop_front();
          if (result_value !== w.value) report("result_value", result_value, w.value);
          if (result_index !== w.index) report("result_index", result_index, w.index);
          if (singular !== w.sing) report("singular", singular, w.sing);
          if (saturated !== w.sat) report("saturated", saturated, w.sat);
          if (last_result !== w.last) report("last_result", last_result, w.last);
          if (w.sing && w.last) singular_seen <= singular_seen + 1;
          if (w.sat) sat_seen <= sat_seen + 1;
        end
      end
      if (element_valid && !element_stall) begin
        matrix_elems[loaded] = element_value;
        if (loaded == 4'd15) predict_inverse();
        loaded <= loaded + 4'd1;
      end
    end
  end

endmodule

// File: tb/matrix4_inverse_tb.sv
// Testbench top for the 4x4 fixed-point matrix inverter: feeds whole matrices in bursts,
// stalls the result side on varying patterns and gives the verdict.
// Depends on m4inv_pkg, matrix4_inverse and matrix4_inverse_checker.
`timescale 1ns / 100ps
module matrix4_inverse_tb;
  import m4inv_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 3000;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              element_valid = 1'b0;
  logic              element_stall;
  logic [ELEM_W-1:0] element_value = '0;
  logic              result_valid;
  logic              result_stall = 1'b0;
  logic [ELEM_W-1:0] result_value;
  logic [IDX_W-1:0]  result_index;
  logic              singular;
  logic              saturated;
  logic              last_result;

  int fail_count;
  int pending;
  int results_seen;
  int singular_seen;
  int sat_seen;

  int   cycles = 0;
  int   burst_left = 0;
  int   matrices_sent = 0;
  bit   hold_go = 1'b0;
  bit   hold_done = 1'b0;
  int   hold_cnt = 0;
  int   stall_mode = 0;
  logic [ELEM_W-1:0] mat [16];

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  matrix4_inverse u_top (.*);

  matrix4_inverse_checker u_checker (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending);
      $display("status: fail");
      $finish;
    end
  end

  // receiver: one long hold on request, otherwise one of four stall patterns, picked anew at intervals
  always @(posedge clk) begin
    if (cycles % 256 == 0) stall_mode <= $urandom_range(0, 3);
    if (hold_go && !hold_done) begin
      hold_done <= 1'b1;
      hold_cnt  <= HOLD_CYCLES;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
    case (stall_mode)
      0:       result_stall <= (hold_cnt > 1);
      1:       result_stall <= (hold_cnt > 1) || ($urandom_range(0, 9) < 3);
      2:       result_stall <= (hold_cnt > 1) || ($urandom_range(0, 9) < 8);
      default: result_stall <= (hold_cnt > 1) || (cycles % 7 < 3);
    endcase
  end

  task automatic send_element(input logic [ELEM_W-1:0] v);
    if (burst_left == 0) begin
      element_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 48 : $urandom_range(1, 16);
    end
    element_valid <= 1'b1;
    element_value <= v;
    do @(posedge clk); while (element_stall);
    burst_left--;
  endtask

  task automatic send_matrix();
    for (int k = 0; k < 16; k++) send_element(mat[k]);
    matrices_sent++;
  endtask

  function automatic logic [ELEM_W-1:0] small_val(input int span);
    return ELEM_W'($signed($urandom_range(0, 2 * span)) - span);
  endfunction

  task automatic make_matrix(input int kind);
    int dup;
    int src;
    int row;
    for (int k = 0; k < 16; k++) begin
      case (kind)
        0:       mat[k] = $urandom();
        1:       mat[k] = small_val(1 << 18);
        2:       mat[k] = (k % 5 == 0) ? small_val(4) : small_val(1) * ELEM_W'($urandom_range(0, 1));
        3:       mat[k] = (k % 5 == 0) ? 32'h0001_0000 + small_val(1 << 12) : small_val(1 << 10);
        default: mat[k] = small_val(1 << 16);
      endcase
    end
    if (kind == 4) begin
      // copy one row onto another, determinant is zero
      dup = $urandom_range(1, 3);
      src = $urandom_range(0, dup - 1);
      for (int c = 0; c < 4; c++) mat[4 * dup + c] = mat[4 * src + c];
    end else if (kind == 5) begin
      row = $urandom_range(0, 3);
      for (int c = 0; c < 4; c++) mat[4 * row + c] = '0;
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // tiny diagonal with mixed signs: inverse overflows both ways; two off-diagonals are extremes
    mat = '{32'd1, POS_MAX, 32'd0, 32'd0,
            32'd0, 32'hFFFF_FFFF, NEG_MIN, 32'd0,
            32'd0, 32'd0, 32'd1, 32'd0,
            32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};
    send_matrix();

    while (matrices_sent < 14) begin
      if (matrices_sent == 2) hold_go = 1'b1;
      if (matrices_sent == 6) begin
        element_valid <= 1'b0;
        // let the checker log the last element before looking at what is outstanding
        @(posedge clk);
        wait (pending == 0);
        @(posedge clk);
      end
      make_matrix($urandom_range(0, 9) < 2 ? $urandom_range(4, 5) : $urandom_range(0, 3));
      send_matrix();
    end
    element_valid <= 1'b0;

    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    $display("covered %0d matrices (%0d singular), %0d results checked, %0d clamped",
             matrices_sent, singular_seen, results_seen, sat_seen);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("status: fail");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/m4inv_pkg.sv
hdl/m4inv_front.sv
hdl/m4inv_fifo.sv
hdl/m4inv_back.sv
hdl/matrix4_inverse.sv
hdl/m4inv_chk.sv
tb/matrix4_inverse_checker.sv
tb/matrix4_inverse_tb.sv
